// ===== sv/ipc_pkg.sv =====
// Shared constants, payload types and table address helper for the partition counter.
package ipc_pkg;

    // Largest total kept in the table and width of one count
    localparam int MAX_N   = 256;
    localparam int COUNT_W = 64;

    // Triangular table: one entry per (n,m) with 1 <= m <= n <= MAX_N
    localparam int TSIZE  = (MAX_N * (MAX_N + 1)) / 2;
    localparam int ADDR_W = $clog2(TSIZE);
    localparam int ROW_W  = $clog2(MAX_N + 1);

    // Width of the request fields
    localparam int FIELD_W = 9;

    typedef struct packed {
        logic [FIELD_W-1:0] total;
        logic [FIELD_W-1:0] max_part;
    } ipc_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] ways;
        logic               saturated;
    } ipc_rsp_t;

    // One table entry: count and its saturation mark
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               mark;
    } ipc_entry_t;

    localparam int ENTRY_W = $bits(ipc_entry_t);

    // Address of entry (n,m): n*(n-1)/2 + m - 1
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] n,
                                                    input logic [ROW_W-1:0] m);
        logic [2*ROW_W-1:0] prod;
        prod = (2*ROW_W)'(n) * (2*ROW_W)'(n - ROW_W'(1));
        return ADDR_W'(prod >> 1) + ADDR_W'(m) - ADDR_W'(1);
    endfunction

endpackage

// ===== sv/ipc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ipc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register one read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/ipc_sat_add.sv =====
// Saturating adder for table counts with saturation marks.
module ipc_sat_add
    import ipc_pkg::*;
(
    input  ipc_entry_t a,
    input  ipc_entry_t b,
    output ipc_entry_t sum
);

    logic [COUNT_W:0] raw;
    logic             clip;

    // Clip on a marked operand, a carry out, or a sum that reaches all ones
    always_comb
    begin
        raw  = {1'b0, a.count} + {1'b0, b.count};
        clip = a.mark || b.mark || raw[COUNT_W] || (&raw[COUNT_W-1:0]);
        if (clip)
        begin
            sum.count = '1;
            sum.mark  = 1'b1;
        end
        else
        begin
            sum.count = raw[COUNT_W-1:0];
            sum.mark  = 1'b0;
        end
    end

endmodule

// ===== sv/integer_partition_count_top.sv =====
// A query on rows already filled passes from S_IDLE through S_QRD and S_QOUT before done
// rises; zero or out-of-range requests raise done straight from S_IDLE. Filling row n on
// demand does one table read-modify-write per entry, waiting in S_ADD when the entry needs
// a lower-row read. A new request is taken only in S_IDLE, once the last one is done.
// Reset clears the controller and the filled-row count; table contents start undefined
// and are never read before being written, so no clearing pass is run.
module integer_partition_count_top
    import ipc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  ipc_req_t req,
    output logic     busy,
    output logic     done,
    output ipc_rsp_t rsp
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FILL = 5'b00010,
        S_ADD  = 5'b00100,
        S_QRD  = 5'b01000,
        S_QOUT = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [ROW_W-1:0]     rows_filled_reg, rows_filled_next;
    logic [ROW_W-1:0]     fill_n_reg, fill_n_next;
    logic [ROW_W-1:0]     fill_m_reg, fill_m_next;
    logic [ROW_W-1:0]     q_n_reg, q_n_next;
    logic [ROW_W-1:0]     q_m_reg, q_m_next;
    ipc_entry_t           prev_reg, prev_next;
    logic                 done_reg, done_next;
    ipc_rsp_t             rsp_reg, rsp_next;

    logic [ROW_W-1:0]     fill_r;
    logic [ROW_W-1:0]     fill_c;
    logic                 is_base;
    logic                 is_diag;
    logic                 wr_en;
    logic [ADDR_W-1:0]    waddr;
    logic [ADDR_W-1:0]    raddr;
    ipc_entry_t           wdata;
    ipc_entry_t           rd_entry;
    ipc_entry_t           add_a;
    ipc_entry_t           add_sum;
    ipc_entry_t           one_entry;
    logic [ENTRY_W-1:0]   rdata_raw;

    // Decode the entry under fill
    always_comb
    begin
        fill_r    = fill_n_reg - fill_m_reg;
        fill_c    = (fill_m_reg < fill_r) ? fill_m_reg : fill_r;
        is_base   = (fill_n_reg == ROW_W'(1)) || (fill_m_reg == ROW_W'(1));
        is_diag   = (fill_m_reg == fill_n_reg);
        one_entry = '{count: COUNT_W'(1), mark: 1'b0};
        rd_entry  = ipc_entry_t'(rdata_raw);
        add_a     = (state_reg == S_ADD) ? rd_entry : one_entry;
    end

    ipc_sat_add u_add (
        .a   (add_a),
        .b   (prev_reg),
        .sum (add_sum)
    );

    // Table memory access
    always_comb
    begin
        wr_en = ((state_reg == S_FILL) && (is_base || is_diag)) || (state_reg == S_ADD);
        waddr = cell_addr(fill_n_reg, fill_m_reg);
        wdata = is_base ? one_entry : add_sum;
        raddr = (state_reg == S_QRD) ? cell_addr(q_n_reg, q_m_reg)
                                     : cell_addr(fill_r, fill_c);
    end

    ipc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TSIZE)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    // Sequence requests, row fills and lookups
    always_comb
    begin
        state_next       = state_reg;
        rows_filled_next = rows_filled_reg;
        fill_n_next      = fill_n_reg;
        fill_m_next      = fill_m_reg;
        q_n_next         = q_n_reg;
        q_m_next         = q_m_reg;
        prev_next        = prev_reg;
        done_next        = 1'b0;
        rsp_next         = rsp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.total == '0)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{ways: COUNT_W'(1), saturated: 1'b0};
                    end
                    else if ((req.max_part == '0) || (32'(req.total) > MAX_N))
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{ways: '0, saturated: 1'b0};
                    end
                    else
                    begin
                        q_n_next = ROW_W'(req.total);
                        q_m_next = (req.max_part > req.total) ? ROW_W'(req.total)
                                                              : ROW_W'(req.max_part);
                        if (32'(rows_filled_reg) < 32'(req.total))
                        begin
                            fill_n_next = rows_filled_reg + ROW_W'(1);
                            fill_m_next = ROW_W'(1);
                            state_next  = S_FILL;
                        end
                        else
                        begin
                            state_next = S_QRD;
                        end
                    end
                end
            end
            S_FILL, S_ADD:
            begin
                if (wr_en)
                begin
                    // Commit the entry, then advance to the next one or, once the requested row is done, to the lookup
                    prev_next = wdata;
                    if (is_diag)
                    begin
                        rows_filled_next = fill_n_reg;
                        if (fill_n_reg == q_n_reg)
                        begin
                            state_next = S_QRD;
                        end
                        else
                        begin
                            fill_n_next = fill_n_reg + ROW_W'(1);
                            fill_m_next = ROW_W'(1);
                            state_next  = S_FILL;
                        end
                    end
                    else
                    begin
                        fill_m_next = fill_m_reg + ROW_W'(1);
                        state_next  = S_FILL;
                    end
                end
                else
                begin
                    // Wait for the lower-row read
                    state_next = S_ADD;
                end
            end
            S_QRD:
            begin
                state_next = S_QOUT;
            end
            S_QOUT:
            begin
                done_next  = 1'b1;
                rsp_next   = '{ways: rd_entry.count, saturated: rd_entry.mark};
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rows_filled_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rows_filled_reg <= rows_filled_next;
            done_reg        <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        fill_n_reg <= fill_n_next;
        fill_m_reg <= fill_m_next;
        q_n_reg    <= q_n_next;
        q_m_reg    <= q_m_next;
        prev_reg   <= prev_next;
        rsp_reg    <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== tb/tb_integer_partition_count_top.sv =====
// Self-checking testbench for the partition counter: directed and random requests.
module tb_integer_partition_count_top;
    import ipc_pkg::*;

    typedef logic [COUNT_W-1:0] count_t;

    localparam count_t ALL_ONES     = '1;
    localparam int     FIELD_MAX    = (1 << FIELD_W) - 1;
    localparam int     PLAN_LEN     = 25;
    localparam int     REQUESTS     = 1900;
    localparam int     QUIET_TAIL   = 200;
    localparam int     STALL_LIMIT  = 300000;
    localparam int     DRAIN_CYCLES = 8;

    // Partition counts predicted per request, checked in request order
    class partition_tally;
        count_t      counts [1:MAX_N][1:MAX_N];
        bit          marks  [1:MAX_N][1:MAX_N];
        int unsigned rows_done;
        ipc_rsp_t    ways_due [$];
        int          errors;
        int          lookups;
        int          empties;
        int          rejects;

        function new();
            rows_done = 0;
            errors    = 0;
            lookups   = 0;
            empties   = 0;
            rejects   = 0;
        endfunction

        // Add two counts, clamping at all ones and carrying the marks
        function void sum_sat(input count_t a, input bit fa, input count_t b, input bit fb,
                              output count_t sum, output bit flag);
            logic [COUNT_W:0] wide;
            wide = {1'b0, a} + {1'b0, b};
            if (fa || fb || wide >= {1'b0, ALL_ONES})
            begin
                sum  = ALL_ONES;
                flag = 1'b1;
            end
            else
            begin
                sum  = wide[COUNT_W-1:0];
                flag = 1'b0;
            end
        endfunction

        // Fill row n from row n itself and lower rows
        function void fill_row(input int n);
            int rest;
            int cap;
            for (int m = 1; m <= n; m++)
            begin
                if (n == 1 || m == 1)
                begin
                    counts[n][m] = count_t'(1);
                    marks[n][m]  = (ALL_ONES == count_t'(1));
                end
                else if (m == n)
                begin
                    sum_sat(count_t'(1), 1'b0, counts[n][n-1], marks[n][n-1],
                            counts[n][m], marks[n][m]);
                end
                else
                begin
                    rest = n - m;
                    cap  = (m < rest) ? m : rest;
                    sum_sat(counts[n][m-1], marks[n][m-1], counts[rest][cap], marks[rest][cap],
                            counts[n][m], marks[n][m]);
                end
            end
        endfunction

        function ipc_rsp_t count_partitions(input ipc_req_t r);
            int       n;
            int       m;
            ipc_rsp_t want;
            n              = r.total;
            m              = r.max_part;
            want.ways      = '0;
            want.saturated = 1'b0;
            if (n == 0)
            begin
                // Empty sum
                want.ways = count_t'(1);
                empties++;
            end
            else if (m == 0 || n > MAX_N)
            begin
                rejects++;
            end
            else
            begin
                // Extend the table on demand, then clamp the part size
                while (rows_done < n)
                begin
                    rows_done++;
                    fill_row(rows_done);
                end
                if (m > n)
                    m = n;
                want.ways      = counts[n][m];
                want.saturated = marks[n][m];
                lookups++;
            end
            return want;
        endfunction

        function void log_request(input ipc_req_t r);
            ways_due.push_back(count_partitions(r));
        endfunction

        function void match_result(input ipc_rsp_t got);
            ipc_rsp_t want;
            if (ways_due.size() == 0)
            begin
                $error("unexpected result: ways %0d, saturated %0b", got.ways, got.saturated);
                errors++;
                return;
            end
            want = ways_due.pop_front();
            if (got.ways !== want.ways)
            begin
                $error("ways: expected %0d, actual %0d", want.ways, got.ways);
                errors++;
            end
            if (got.saturated !== want.saturated)
            begin
                $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
                errors++;
            end
        endfunction

        function int outstanding();
            return ways_due.size();
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    ipc_req_t req;
    logic     busy;
    logic     done;
    ipc_rsp_t rsp;

    partition_tally tally = new();
    int             stall_cycles = 0;

    // Directed requests: empty, null and out-of-range cases mixed with rows of rising size
    int plan [PLAN_LEN][2] = '{
        '{0, 0}, '{0, FIELD_MAX}, '{1, 0}, '{1, 1}, '{1, FIELD_MAX},
        '{2, 1}, '{2, 2}, '{5, 3}, '{5, 5}, '{5, 9},
        '{10, 9}, '{10, 10}, '{40, 7}, '{100, 50}, '{100, 0},
        '{255, 128}, '{256, 1}, '{256, 255}, '{256, MAX_N}, '{256, FIELD_MAX},
        '{MAX_N + 1, 1}, '{300, 0}, '{FIELD_MAX, FIELD_MAX}, '{1, MAX_N}, '{0, MAX_N}
    };

    integer_partition_count_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Check each result and watch for a stalled run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
                tally.match_result(rsp);
            if ((start && !busy) || done === 1'b1)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Present one request and hold it until the block takes it
    task automatic issue(input ipc_req_t r);
        if (start !== 1'b1)
            start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tally.log_request(r);
    endtask

    // Mostly well-formed queries, some empty, null and out-of-range noise
    function automatic ipc_req_t random_request();
        ipc_req_t r;
        int       pick;
        int       n;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            r.total    = '0;
            r.max_part = FIELD_W'($urandom_range(0, FIELD_MAX));
        end
        else if (pick < 10)
        begin
            r.total    = FIELD_W'($urandom_range(1, FIELD_MAX));
            r.max_part = '0;
        end
        else if (pick < 15)
        begin
            r.total    = FIELD_W'($urandom_range(MAX_N + 1, FIELD_MAX));
            r.max_part = FIELD_W'($urandom_range(0, FIELD_MAX));
        end
        else
        begin
            n       = ($urandom_range(0, 1) == 0) ? $urandom_range(1, MAX_N)
                                                  : $urandom_range(1, 40);
            r.total = FIELD_W'(n);
            case ($urandom_range(0, 3))
                0:       r.max_part = FIELD_W'(n);
                1:       r.max_part = FIELD_W'($urandom_range(1, FIELD_MAX));
                default: r.max_part = FIELD_W'($urandom_range(1, n));
            endcase
        end
        return r;
    endfunction

    initial
    begin
        ipc_req_t r;
        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int idx = 0; idx < REQUESTS; idx++)
        begin
            if (idx < PLAN_LEN)
            begin
                r.total    = FIELD_W'(plan[idx][0]);
                r.max_part = FIELD_W'(plan[idx][1]);
            end
            else
            begin
                r = random_request();
            end
            issue(r);
            // Idle in bursts during alternate stretches, none near the end
            if (idx < REQUESTS - QUIET_TAIL && (idx / 150) % 2 == 0 &&
                $urandom_range(0, 2) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
        start <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (tally.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d table lookups, %0d empty totals, %0d null or out of range.",
                 REQUESTS, tally.lookups, tally.empties, tally.rejects);
        $display("Table rows filled on demand up to %0d; %0d mismatches seen.",
                 tally.rows_done, tally.errors);
        if (tally.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
